// ===== rtl/double_word_restoring_divider_core_defines.svh =====
// assertion macros shared by the divider files
`ifndef DOUBLE_WORD_RESTORING_DIVIDER_CORE_DEFINES_SVH
`define DOUBLE_WORD_RESTORING_DIVIDER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DWRD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dwrd same-cycle check failed");

// next-cycle implication, disabled during reset
`define DWRD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dwrd next-cycle check failed");

`endif

// ===== rtl/dwrd_pkg.sv =====
package dwrd_pkg;

   localparam int FIELD_BITS = 64;

   typedef logic [FIELD_BITS-1:0] word_type;

endpackage

// ===== rtl/dwrd_cell.sv =====
`include "double_word_restoring_divider_core_defines.svh"

module dwrd_cell #(
   parameter int WORD_WIDTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [WORD_WIDTH-1:0] in_rem,
   input  logic [WORD_WIDTH-1:0] in_lo,
   input  logic [WORD_WIDTH-1:0] in_q,
   input  logic [WORD_WIDTH-1:0] in_d,
   input  logic                  in_viol,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [WORD_WIDTH-1:0] out_rem,
   output logic [WORD_WIDTH-1:0] out_lo,
   output logic [WORD_WIDTH-1:0] out_q,
   output logic [WORD_WIDTH-1:0] out_d,
   output logic                  out_viol
);

   import dwrd_pkg::*;

   logic                  valid_ff;
   logic                  valid_in;
   logic [WORD_WIDTH-1:0] rem_ff;
   logic [WORD_WIDTH-1:0] rem_in;
   logic [WORD_WIDTH-1:0] lo_ff;
   logic [WORD_WIDTH-1:0] lo_in;
   logic [WORD_WIDTH-1:0] q_ff;
   logic [WORD_WIDTH-1:0] q_in;
   logic [WORD_WIDTH-1:0] d_ff;
   logic                  viol_ff;
   logic                  load;
   logic                  carry;
   logic [WORD_WIDTH-1:0] shifted;
   logic [WORD_WIDTH-1:0] diff;
   logic                  take;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = load || (valid_ff && !out_ready);

   // one restoring step
   always_comb begin
      carry   = in_rem[WORD_WIDTH-1];
      shifted = {in_rem[WORD_WIDTH-2:0], in_lo[WORD_WIDTH-1]};
      diff    = shifted - in_d;
      take    = carry || (shifted >= in_d);
      lo_in   = {in_lo[WORD_WIDTH-2:0], 1'b0};
      q_in    = {in_q[WORD_WIDTH-2:0], take};
      rem_in  = take ? diff : shifted;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff  <= rem_in;
         lo_ff   <= lo_in;
         q_ff    <= q_in;
         d_ff    <= in_d;
         viol_ff <= in_viol;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_lo    = lo_ff;
   assign out_q     = q_ff;
   assign out_d     = d_ff;
   assign out_viol  = viol_ff;

   `DWRD_ASSERT_SAME(a_rem_below_divisor, clock, reset, valid_ff && !viol_ff, rem_ff < d_ff)
   `DWRD_ASSERT_NEXT(a_stall_holds, clock, reset, valid_ff && !out_ready, valid_ff && $stable(q_ff) && $stable(rem_ff))
   `DWRD_ASSERT_SAME(a_no_load_when_full, clock, reset, valid_ff && !out_ready, !load)

endmodule

// ===== rtl/double_word_restoring_divider_core.sv =====
// Pipelined 2W-by-W restoring divider: a row of WORD_WIDTH identical cells, each performing
// one shift-subtract step and passing its partial remainder, remaining dividend bits,
// quotient bits and divisor to the next cell. One division is accepted per cycle while
// req_ready is high; each result passes through every cell of the row in turn. Every
// cell holds its item while the cell after it is full, so a stall on the result side
// backs up the row cell by cell and the input keeps taking transfers until the row is full.
// precondition_violated flags a divisor with its top bit clear or a high word not below the
// divisor; quotient and remainder are then the truncated loop result. Input bits above
// WORD_WIDTH are ignored and result bits above WORD_WIDTH read zero.
`include "double_word_restoring_divider_core_defines.svh"

module double_word_restoring_divider_core #(
   parameter int WORD_WIDTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  dwrd_pkg::word_type req_dividend_high,
   input  dwrd_pkg::word_type req_dividend_low,
   input  dwrd_pkg::word_type req_divisor,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output dwrd_pkg::word_type rsp_quotient,
   output dwrd_pkg::word_type rsp_remainder,
   output logic               rsp_precondition_violated
);

   import dwrd_pkg::*;

   logic                  valid  [WORD_WIDTH+1];
   logic                  ready  [WORD_WIDTH+1];
   logic [WORD_WIDTH-1:0] rem    [WORD_WIDTH+1];
   logic [WORD_WIDTH-1:0] lo     [WORD_WIDTH+1];
   logic [WORD_WIDTH-1:0] q      [WORD_WIDTH+1];
   logic [WORD_WIDTH-1:0] d      [WORD_WIDTH+1];
   logic                  viol   [WORD_WIDTH+1];

   // entry into the first cell
   assign valid[0] = req_valid;
   assign req_ready = ready[0];
   assign rem[0]   = req_dividend_high[WORD_WIDTH-1:0];
   assign lo[0]    = req_dividend_low[WORD_WIDTH-1:0];
   assign q[0]     = '0;
   assign d[0]     = req_divisor[WORD_WIDTH-1:0];
   assign viol[0]  = (rem[0] >= d[0]) || !d[0][WORD_WIDTH-1];

   for (genvar i = 0; i < WORD_WIDTH; i++) begin : g_cell
      dwrd_cell #(
         .WORD_WIDTH(WORD_WIDTH)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid[i]),
         .in_ready  (ready[i]),
         .in_rem    (rem[i]),
         .in_lo     (lo[i]),
         .in_q      (q[i]),
         .in_d      (d[i]),
         .in_viol   (viol[i]),
         .out_valid (valid[i+1]),
         .out_ready (ready[i+1]),
         .out_rem   (rem[i+1]),
         .out_lo    (lo[i+1]),
         .out_q     (q[i+1]),
         .out_d     (d[i+1]),
         .out_viol  (viol[i+1])
      );
   end

   assign ready[WORD_WIDTH]         = rsp_ready;
   assign rsp_valid                 = valid[WORD_WIDTH];
   assign rsp_quotient              = FIELD_BITS'(q[WORD_WIDTH]);
   assign rsp_remainder             = FIELD_BITS'(rem[WORD_WIDTH]);
   assign rsp_precondition_violated = viol[WORD_WIDTH];

   `DWRD_ASSERT_SAME(a_ready_when_empty_out, clock, reset, !rsp_valid, req_ready)
   `DWRD_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !rsp_valid)
   `DWRD_ASSERT_SAME(a_ready_tracks_output, clock, reset, rsp_ready, req_ready)

endmodule
